// ----- hw/rtl/tkpq_pkg.sv -----
// Shared types, codes and key compare for the two-key min priority queue.
package tkpq_pkg;

	typedef struct packed {
		logic [31:0] position;
		logic [31:0] weight;
	} entry_t;

	typedef enum logic [1:0] {
		STATUS_OK        = 2'd0,
		STATUS_OVERFLOW  = 2'd1,
		STATUS_UNDERFLOW = 2'd2
	} status_t;

	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP  = 1'b1;

	// Command broadcast to every cell in the chain.
	typedef struct packed {
		logic   push;
		logic   pop;
		entry_t ent;
	} cmd_t;

	// True when a sorts strictly before b.
	function automatic logic key_less(entry_t a, entry_t b);
		return (a.position < b.position) ||
			((a.position == b.position) && (a.weight < b.weight));
	endfunction

endpackage

// ----- hw/rtl/tkpq_cell.sv -----
// One slot of the sorted shift-register array.
module tkpq_cell #(
	parameter int IDX = 0,
	parameter int CW  = 7
) (
	input  logic             clk,
	input  tkpq_pkg::cmd_t   cmd,
	input  logic [CW-1:0]    count,
	input  logic             prev_gt,
	input  tkpq_pkg::entry_t prev_entry,
	input  tkpq_pkg::entry_t next_entry,
	output logic             gt,
	output tkpq_pkg::entry_t entry
);

	tkpq_pkg::entry_t entry_q;
	logic             occupied;
	logic             at_end;

	assign occupied = count > CW'(IDX);
	assign at_end   = count == CW'(IDX);
	// Stored key is larger than the one being pushed: new item goes at or before here.
	assign gt       = occupied && tkpq_pkg::key_less(cmd.ent, entry_q);
	assign entry    = entry_q;

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			if (prev_gt) begin
				entry_q <= prev_entry;
			end else if (gt || at_end) begin
				entry_q <= cmd.ent;
			end
		end else if (cmd.pop) begin
			entry_q <= next_entry;
		end
	end

endmodule

// ----- hw/rtl/two_key_min_priority_queue_core.sv -----
// Top level of the two-key min priority queue: cell chain, count and result register.
// Usage:
//   Request channel (req_valid / req_stall) carries operation, key_position and
//   key_weight. operation OP_PUSH inserts (position, weight) in sorted order,
//   OP_POP removes the head. Keys are ignored on a pop.
//   Response channel (rsp_valid / rsp_stall) returns one item per request:
//   the popped entry (zero on a push), the new head (zero when empty),
//   queue_empty and status (ok, overflow on a full push, underflow on an
//   empty pop). Overflow and underflow leave the queue unchanged.
// Timing:
//   Every cell compares the pushed key with its own entry and shifts in the
//   same cycle, so one item is taken each cycle while req_stall is low. The
//   response appears in the result register in the cycle after acceptance.
//   req_stall is high only while a response waits and rsp_stall holds it;
//   the response register then holds its item unchanged.
// Reset:
//   arst_n clears the entry count and the response valid; the queue starts
//   empty and needs no clearing pass.
module two_key_min_priority_queue_core #(
	parameter int DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic        operation,
	input  logic [31:0] key_position,
	input  logic [31:0] key_weight,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [31:0] popped_position,
	output logic [31:0] popped_weight,
	output logic [31:0] head_position,
	output logic [31:0] head_weight,
	output logic        queue_empty,
	output logic [1:0]  status
);

	localparam int CW = $clog2(DEPTH + 1);

	logic [CW-1:0]    count_q;
	logic [CW-1:0]    count_next;
	logic             accept;
	logic             full;
	logic             empty;
	tkpq_pkg::cmd_t   cmd;
	tkpq_pkg::entry_t req_entry;
	tkpq_pkg::entry_t entries [DEPTH];
	logic             gts     [DEPTH];
	tkpq_pkg::entry_t popped_d;
	tkpq_pkg::entry_t head_d;
	tkpq_pkg::status_t status_d;

	tkpq_pkg::entry_t popped_q;
	tkpq_pkg::entry_t head_q;
	logic             empty_q;
	tkpq_pkg::status_t status_q;
	logic             rsp_valid_q;

	assign req_stall = rsp_valid_q && rsp_stall;
	assign accept    = req_valid && !req_stall;
	assign full      = count_q == CW'(DEPTH);
	assign empty     = count_q == '0;

	assign req_entry.position = key_position;
	assign req_entry.weight   = key_weight;

	assign cmd.push = accept && (operation == tkpq_pkg::OP_PUSH) && !full;
	assign cmd.pop  = accept && (operation == tkpq_pkg::OP_POP) && !empty;
	assign cmd.ent  = req_entry;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		tkpq_pkg::entry_t prev_e;
		tkpq_pkg::entry_t next_e;
		logic             prev_g;
		if (i == 0) begin : g_first
			assign prev_e = '0;
			assign prev_g = 1'b0;
		end else begin : g_mid
			assign prev_e = entries[i-1];
			assign prev_g = gts[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign next_e = entries[i];
		end else begin : g_inner
			assign next_e = entries[i+1];
		end
		tkpq_cell #(
			.IDX (i),
			.CW  (CW)
		) u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.count      (count_q),
			.prev_gt    (prev_g),
			.prev_entry (prev_e),
			.next_entry (next_e),
			.gt         (gts[i]),
			.entry      (entries[i])
		);
	end

	always_comb begin
		count_next = count_q;
		popped_d   = '0;
		head_d     = entries[0];
		status_d   = tkpq_pkg::STATUS_OK;
		if (operation == tkpq_pkg::OP_PUSH) begin
			if (full) begin
				status_d = tkpq_pkg::STATUS_OVERFLOW;
			end else begin
				count_next = count_q + CW'(1);
				if (empty || gts[0]) begin
					head_d = req_entry;
				end
			end
		end else begin
			if (empty) begin
				status_d = tkpq_pkg::STATUS_UNDERFLOW;
			end else begin
				count_next = count_q - CW'(1);
				popped_d   = entries[0];
				head_d     = entries[1];
			end
		end
		if (count_next == '0) begin
			head_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_next;
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			popped_q <= popped_d;
			head_q   <= head_d;
			empty_q  <= count_next == '0;
			status_q <= status_d;
		end
	end

	assign rsp_valid       = rsp_valid_q;
	assign popped_position = popped_q.position;
	assign popped_weight   = popped_q.weight;
	assign head_position   = head_q.position;
	assign head_weight     = head_q.weight;
	assign queue_empty     = empty_q;
	assign status          = status_q;

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count above depth");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |=> count_q == $past(count_q) + CW'(1))
		else $error("push did not grow the queue");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> (empty_q == (count_q == '0)))
		else $error("empty flag disagrees with count");

	a_head_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q > CW'(1)) |-> !tkpq_pkg::key_less(entries[1], entries[0]))
		else $error("head cells out of order");
`endif

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the two-key min priority queue core: predictor, driver, monitor.
module tb_top;

	localparam int QUEUE_DEPTH = 64;
	localparam int CYCLE_LIMIT = 200000;
	localparam int BATCH_ITEMS = 250;
	localparam int BATCHES     = 8;
	localparam int HOLD_CYCLES = 400;

	typedef struct packed {
		logic        op;
		logic [31:0] pos;
		logic [31:0] wt;
	} queue_op_t;

	typedef struct packed {
		logic [31:0]       popped_pos;
		logic [31:0]       popped_wt;
		logic [31:0]       head_pos;
		logic [31:0]       head_wt;
		logic              empty;
		tkpq_pkg::status_t st;
	} queue_rsp_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_stall;
	logic        operation = tkpq_pkg::OP_PUSH;
	logic [31:0] key_position = '0;
	logic [31:0] key_weight = '0;
	logic        rsp_valid;
	logic        rsp_stall = 1'b0;
	logic [31:0] popped_position;
	logic [31:0] popped_weight;
	logic [31:0] head_position;
	logic [31:0] head_weight;
	logic        queue_empty;
	logic [1:0]  status;

	queue_op_t        pending_ops[$];
	queue_rsp_t       predicted_results[$];
	tkpq_pkg::entry_t sorted_entries[$];

	int  items_queued = 0;
	int  responses_seen = 0;
	int  error_count = 0;
	int  cycle_count = 0;
	int  send_idle_pct = 0;
	int  recv_stall_pct = 0;
	int  hold_count = 0;
	logic req_taken = 1'b0;
	logic pressure_armed = 1'b0;
	logic pressure_done = 1'b0;

	two_key_min_priority_queue_core #(.DEPTH(QUEUE_DEPTH)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.operation(operation),
		.key_position(key_position),
		.key_weight(key_weight),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.popped_position(popped_position),
		.popped_weight(popped_weight),
		.head_position(head_position),
		.head_weight(head_weight),
		.queue_empty(queue_empty),
		.status(status)
	);

	always #1 clk = ~clk;

	// Sorted list kept head first; a push goes after every entry with an equal or smaller key.
	function automatic queue_rsp_t apply_queue_op(queue_op_t q);
		queue_rsp_t       r;
		tkpq_pkg::entry_t fresh;
		tkpq_pkg::entry_t head;
		int               at;
		r = '0;
		r.st = tkpq_pkg::STATUS_OK;
		if (q.op == tkpq_pkg::OP_PUSH) begin
			if (sorted_entries.size() >= QUEUE_DEPTH) begin
				r.st = tkpq_pkg::STATUS_OVERFLOW;
			end else begin
				fresh.position = q.pos;
				fresh.weight = q.wt;
				at = sorted_entries.size();
				while (at > 0 && ((q.pos < sorted_entries[at-1].position) ||
						(q.pos == sorted_entries[at-1].position &&
						q.wt < sorted_entries[at-1].weight)))
					at--;
				sorted_entries.insert(at, fresh);
			end
		end else begin
			if (sorted_entries.size() == 0) begin
				r.st = tkpq_pkg::STATUS_UNDERFLOW;
			end else begin
				head = sorted_entries.pop_front();
				r.popped_pos = head.position;
				r.popped_wt = head.weight;
			end
		end
		if (sorted_entries.size() != 0) begin
			r.head_pos = sorted_entries[0].position;
			r.head_wt = sorted_entries[0].weight;
			r.empty = 1'b0;
		end else begin
			r.empty = 1'b1;
		end
		return r;
	endfunction

	task automatic report_mismatch(string what);
		$display("mismatch at cycle %0d: %s", cycle_count, what);
		error_count++;
	endtask

	task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %h expected %h", name, got, want));
	endtask

	task automatic add_item(logic op, logic [31:0] pos, logic [31:0] wt);
		queue_op_t q;
		q.op = op;
		q.pos = pos;
		q.wt = wt;
		pending_ops.push_back(q);
		items_queued++;
	endtask

	// Half the time an extreme or small value, so that ties on position and on both keys come up often.
	function automatic logic [31:0] pick_key();
		case ($urandom_range(7))
			0: return 32'h0;
			1: return 32'hFFFF_FFFF;
			2, 3: return 32'($urandom_range(3));
			default: return $urandom();
		endcase
	endfunction

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Long receiver hold-off while the sender keeps offering items.
	always @(posedge clk) begin
		if (pressure_armed && !pressure_done) begin
			hold_count <= HOLD_CYCLES;
			pressure_done <= 1'b1;
		end else if (hold_count != 0) begin
			hold_count <= hold_count - 1;
		end
	end

	always @(negedge clk) begin : drive_requests
		queue_op_t next_op;
		if (arst_n && (!req_valid || req_taken)) begin
			if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				next_op = pending_ops.pop_front();
				req_valid <= 1'b1;
				operation <= next_op.op;
				key_position <= next_op.pos;
				key_weight <= next_op.wt;
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (hold_count != 0)
			rsp_stall <= 1'b1;
		else
			rsp_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// Check before predicting: a response never belongs to the item taken at the same edge.
	always @(posedge clk) begin : score_results
		queue_rsp_t want;
		queue_op_t  taken;
		if (arst_n && rsp_valid && !rsp_stall) begin
			responses_seen++;
			if (predicted_results.size() == 0) begin
				report_mismatch("response with no item outstanding");
			end else begin
				want = predicted_results.pop_front();
				check_field("popped_position", popped_position, want.popped_pos);
				check_field("popped_weight", popped_weight, want.popped_wt);
				check_field("head_position", head_position, want.head_pos);
				check_field("head_weight", head_weight, want.head_wt);
				check_field("queue_empty", 32'(queue_empty), 32'(want.empty));
				check_field("status", 32'(status), 32'(want.st));
			end
		end
		if (arst_n && req_valid && !req_stall) begin
			taken.op = operation;
			taken.pos = key_position;
			taken.wt = key_weight;
			predicted_results.push_back(apply_queue_op(taken));
		end
		req_taken = req_valid && !req_stall;
	end

	initial begin : stimulus
		int idle_pct[4];
		int stall_pct[4];
		int b;
		int n;
		int run_len;
		int push_pct;
		idle_pct = '{0, 46, 0, 7};
		stall_pct = '{0, 0, 46, 7};
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		// directed: empty pop, key extremes, ties on position, drain past empty
		add_item(tkpq_pkg::OP_POP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		add_item(tkpq_pkg::OP_PUSH, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		add_item(tkpq_pkg::OP_PUSH, 32'h0, 32'h0);
		add_item(tkpq_pkg::OP_PUSH, 32'h0, 32'hFFFF_FFFF);
		add_item(tkpq_pkg::OP_PUSH, 32'hFFFF_FFFF, 32'h0);
		add_item(tkpq_pkg::OP_PUSH, 32'd5, 32'd7);
		add_item(tkpq_pkg::OP_PUSH, 32'd5, 32'd3);
		add_item(tkpq_pkg::OP_PUSH, 32'd5, 32'd7);
		add_item(tkpq_pkg::OP_PUSH, 32'h8000_0000, 32'h0000_0001);
		add_item(tkpq_pkg::OP_PUSH, 32'h7FFF_FFFF, 32'h8000_0000);
		for (n = 0; n < 10; n++)
			add_item(tkpq_pkg::OP_POP, $urandom(), $urandom());
		add_item(tkpq_pkg::OP_POP, 32'h0, 32'h0);
		while (responses_seen < items_queued)
			@(posedge clk);

		for (b = 0; b < BATCHES; b++) begin
			@(posedge clk);
			send_idle_pct <= idle_pct[b % 4];
			recv_stall_pct <= stall_pct[b % 4];
			if (b == 0)
				pressure_armed <= 1'b1;
			n = 0;
			// runs that lean to pushes fill the queue, runs that lean to pops drain it
			while (n < BATCH_ITEMS) begin
				run_len = $urandom_range(30, 150);
				case ($urandom_range(2))
					0: push_pct = 90;
					1: push_pct = 50;
					default: push_pct = 10;
				endcase
				while (run_len > 0 && n < BATCH_ITEMS) begin
					add_item(($urandom_range(99) < push_pct) ?
						tkpq_pkg::OP_PUSH : tkpq_pkg::OP_POP,
						pick_key(), pick_key());
					run_len--;
					n++;
				end
			end
			while (responses_seen < items_queued)
				@(posedge clk);
		end

		repeat (8) @(posedge clk);
		if (error_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
